/* hw/rtl/ppool_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the particle pool.
package ppool_pkg;

  localparam int POOL_SIZE_DEF = 64;

  localparam logic [15:0] DECAY_RESET = 16'd256;
  localparam logic [15:0] LIFE_FULL   = 16'h8000;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_ADD  = 2'd1;
  localparam logic [1:0] OP_DRAW = 2'd2;

  localparam logic [1:0] KIND_ALLOC = 2'd0;
  localparam logic [1:0] KIND_DRAW  = 2'd1;
  localparam logic [1:0] KIND_NONE  = 2'd2;

  localparam logic REG_DECAY = 1'b0;

  typedef struct packed {
    logic load_item;
    logic scan_clr;
    logic scan_from_ss;
    logic scan_step;
    logic tick_rd;
    logic found_set;
    logic add_commit;
    logic draw_rd;
    logic emit_pend;
    logic emit_last;
    logic emit_none;
  } ppool_cmd_t;

  typedef struct packed {
    logic live;
    logic cnt_end;
    logic have_pend;
    logic out_free;
  } ppool_sts_t;

endpackage

/* hw/rtl/particle_pool_next_fit_allocator_unit.sv */
// Top level of the particle slot pool with next-fit allocation.
//
//  channel | direction | handshake              | payload
//  in_     | input     | in_valid / in_ready    | operation, delta_time, pos_x, pos_y, width, color
//  out_    | output    | out_valid / out_ready  | kind, slot_index, overwrote, draw_*, last
//  apb     | input     | psel/penable/pwrite    | paddr, pwdata, prdata (decay_rate)
//
// One item at a time. Tick reads one slot of the life RAM per cycle and writes the live
// slots back. Add tests one live bit per cycle, then waits while an earlier result still
// holds the output register. Draw scans every slot and holds the scan while the result
// channel stalls a pending slot.
// A result waits in an output register; the next item is taken while it waits.
// Reset clears all live bits at once; no clearing pass.
module particle_pool_next_fit_allocator_unit
  import ppool_pkg::*;
#(
  parameter int POOL_SIZE = POOL_SIZE_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_operation,
  input  logic [15:0]        in_delta_time,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic [15:0]        in_width,
  input  logic [31:0]        in_color,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_kind,
  output logic [5:0]         out_slot_index,
  output logic               out_overwrote,
  output logic signed [15:0] out_draw_x,
  output logic signed [15:0] out_draw_y,
  output logic [15:0]        out_draw_width,
  output logic [31:0]        out_draw_color,
  output logic               out_last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [15:0] decay_rate_r;
  ppool_cmd_t  cmd;
  ppool_sts_t  sts;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decay_rate_r <= DECAY_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_DECAY)) begin
      decay_rate_r <= pwdata[15:0];
    end
  end

  assign prdata = (paddr[2] == REG_DECAY) ? {16'b0, decay_rate_r} : 32'b0;

  ppool_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_ready     (in_ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  ppool_dpath #(.POOL_SIZE(POOL_SIZE)) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .decay_rate     (decay_rate_r),
    .in_delta_time  (in_delta_time),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_width       (in_width),
    .in_color       (in_color),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_slot_index (out_slot_index),
    .out_overwrote  (out_overwrote),
    .out_draw_x     (out_draw_x),
    .out_draw_y     (out_draw_y),
    .out_draw_width (out_draw_width),
    .out_draw_color (out_draw_color),
    .out_last       (out_last)
  );

endmodule

/* hw/rtl/ppool_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ppool_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/ppool_ctrl.sv */
// Controller state machine: sequences tick, next-fit search and draw scans.
module ppool_ctrl
  import ppool_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_operation,
  output logic       in_ready,
  input  ppool_sts_t sts,
  output ppool_cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_TICK   = 3'd1;
  localparam logic [2:0] S_TFLUSH = 3'd2;
  localparam logic [2:0] S_SEARCH = 3'd3;
  localparam logic [2:0] S_ADD    = 3'd4;
  localparam logic [2:0] S_DRAW   = 3'd5;
  localparam logic [2:0] S_DEND   = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item    = 1'b1;
          cmd.scan_clr     = 1'b1;
          cmd.scan_from_ss = (in_operation == OP_ADD);
          case (in_operation)
            OP_TICK: state_nxt = S_TICK;
            OP_ADD:  state_nxt = S_SEARCH;
            OP_DRAW: state_nxt = S_DRAW;
            default: state_nxt = S_IDLE;  // unused code: drop
          endcase
        end
      end
      S_TICK: begin
        cmd.tick_rd = 1'b1;
        if (sts.cnt_end) begin
          state_nxt = S_TFLUSH;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_TFLUSH: begin
        // last write-back of the life pipeline lands here
        state_nxt = S_IDLE;
      end
      S_SEARCH: begin
        if (!sts.live) begin
          cmd.found_set = 1'b1;
          state_nxt     = S_ADD;
        end else if (sts.cnt_end) begin
          state_nxt = S_ADD;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_ADD: begin
        if (sts.out_free) begin
          cmd.add_commit = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_DRAW: begin
        // hold the scan while a pending slot cannot be handed out
        if (!(sts.live && sts.have_pend && !sts.out_free)) begin
          if (sts.live) begin
            cmd.draw_rd   = 1'b1;
            cmd.emit_pend = sts.have_pend;
          end
          if (sts.cnt_end) begin
            state_nxt = S_DEND;
          end else begin
            cmd.scan_step = 1'b1;
          end
        end
      end
      S_DEND: begin
        if (sts.out_free) begin
          if (sts.have_pend) begin
            cmd.emit_pend = 1'b1;
            cmd.emit_last = 1'b1;
          end else begin
            cmd.emit_none = 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

/* hw/rtl/ppool_dpath.sv */
// Datapath: slot stores, live bits, scan counters, tick arithmetic and result register.
module ppool_dpath
  import ppool_pkg::*;
#(
  parameter int POOL_SIZE = POOL_SIZE_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ppool_cmd_t         cmd,
  output ppool_sts_t         sts,
  input  logic [15:0]        decay_rate,
  input  logic [15:0]        in_delta_time,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic [15:0]        in_width,
  input  logic [31:0]        in_color,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_kind,
  output logic [5:0]         out_slot_index,
  output logic               out_overwrote,
  output logic signed [15:0] out_draw_x,
  output logic signed [15:0] out_draw_y,
  output logic [15:0]        out_draw_width,
  output logic [31:0]        out_draw_color,
  output logic               out_last
);

  localparam int IDX_W = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(POOL_SIZE - 1);
  localparam int PAY_W = 80;

  // captured item
  logic signed [15:0] pos_x_r, pos_y_r;
  logic [15:0]        width_r;
  logic [31:0]        color_r;
  logic [30:0]        dec_r;
  logic [31:0]        dec_prod;

  // scan control
  logic [IDX_W-1:0]     cnt_r, idx_r, idx_inc;
  logic [IDX_W-1:0]     search_start_r, slot_r;
  logic                 found_r;
  logic [POOL_SIZE-1:0] live_r;

  // tick pipeline
  logic             pipe_v_r;
  logic [IDX_W-1:0] pipe_idx_r;
  logic [15:0]      life_rdata, life_new, life_wdata;
  logic [IDX_W-1:0] life_waddr;
  logic             life_we;

  // draw pending slot
  logic             have_pend_r;
  logic [IDX_W-1:0] pend_idx_r;
  logic [PAY_W-1:0] pay_rdata;

  // result register
  logic               out_valid_r;
  logic [1:0]         out_kind_r;
  logic [5:0]         out_slot_r;
  logic               out_over_r;
  logic signed [15:0] out_x_r, out_y_r;
  logic [15:0]        out_w_r;
  logic [31:0]        out_c_r;
  logic               out_last_r;
  logic               out_free;

  assign dec_prod = 32'(decay_rate) * 32'(in_delta_time);
  assign idx_inc  = (idx_r == IDX_MAX) ? '0 : idx_r + 1'b1;
  assign out_free = !out_valid_r || out_ready;

  assign life_new = ({15'b0, life_rdata} > dec_r) ? life_rdata - dec_r[15:0] : 16'd0;

  always_comb begin
    life_we    = 1'b0;
    life_waddr = pipe_idx_r;
    life_wdata = life_new;
    if (cmd.add_commit) begin
      life_we    = 1'b1;
      life_waddr = slot_r;
      life_wdata = LIFE_FULL;
    end else if (pipe_v_r) begin
      life_we = 1'b1;
    end
  end

  ppool_ram #(.WIDTH(16), .DEPTH(POOL_SIZE)) u_life_ram (
    .clk   (clk),
    .we    (life_we),
    .waddr (life_waddr),
    .wdata (life_wdata),
    .re    (cmd.tick_rd),
    .raddr (idx_r),
    .rdata (life_rdata)
  );

  ppool_ram #(.WIDTH(PAY_W), .DEPTH(POOL_SIZE)) u_pay_ram (
    .clk   (clk),
    .we    (cmd.add_commit),
    .waddr (slot_r),
    .wdata ({pos_x_r, pos_y_r, width_r, color_r}),
    .re    (cmd.draw_rd),
    .raddr (idx_r),
    .rdata (pay_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      pos_x_r <= in_pos_x;
      pos_y_r <= in_pos_y;
      width_r <= in_width;
      color_r <= in_color;
      dec_r   <= dec_prod[31:1];
    end
    if (cmd.scan_clr) begin
      cnt_r <= '0;
      idx_r <= cmd.scan_from_ss ? search_start_r : '0;
    end else if (cmd.scan_step) begin
      cnt_r <= cnt_r + 1'b1;
      idx_r <= idx_inc;
    end
    if (cmd.scan_clr) begin
      slot_r <= '0;
    end else if (cmd.found_set) begin
      slot_r <= idx_r;
    end
    pipe_idx_r <= idx_r;
    if (cmd.draw_rd) begin
      pend_idx_r <= idx_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r         <= '0;
      search_start_r <= '0;
      found_r        <= 1'b0;
      pipe_v_r       <= 1'b0;
      have_pend_r    <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      pipe_v_r <= cmd.tick_rd && live_r[idx_r];
      if (pipe_v_r) begin
        live_r[pipe_idx_r] <= (life_new != 16'd0);
      end
      if (cmd.add_commit) begin
        live_r[slot_r] <= 1'b1;
        if (found_r) begin
          search_start_r <= slot_r;
        end
      end
      if (cmd.scan_clr) begin
        found_r <= 1'b0;
      end else if (cmd.found_set) begin
        found_r <= 1'b1;
      end
      if (cmd.scan_clr) begin
        have_pend_r <= 1'b0;
      end else if (cmd.draw_rd) begin
        have_pend_r <= 1'b1;
      end else if (cmd.emit_pend) begin
        have_pend_r <= 1'b0;
      end
      if (cmd.add_commit || cmd.emit_pend || cmd.emit_none) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.add_commit) begin
      out_kind_r <= KIND_ALLOC;
      out_slot_r <= 6'(slot_r);
      out_over_r <= !found_r;
      out_x_r    <= '0;
      out_y_r    <= '0;
      out_w_r    <= '0;
      out_c_r    <= '0;
      out_last_r <= 1'b1;
    end else if (cmd.emit_pend) begin
      out_kind_r <= KIND_DRAW;
      out_slot_r <= 6'(pend_idx_r);
      out_over_r <= 1'b0;
      out_x_r    <= pay_rdata[79:64];
      out_y_r    <= pay_rdata[63:48];
      out_w_r    <= pay_rdata[47:32];
      out_c_r    <= pay_rdata[31:0];
      out_last_r <= cmd.emit_last;
    end else if (cmd.emit_none) begin
      out_kind_r <= KIND_NONE;
      out_slot_r <= '0;
      out_over_r <= 1'b0;
      out_x_r    <= '0;
      out_y_r    <= '0;
      out_w_r    <= '0;
      out_c_r    <= '0;
      out_last_r <= 1'b1;
    end
  end

  assign sts.live      = live_r[idx_r];
  assign sts.cnt_end   = (cnt_r == IDX_MAX);
  assign sts.have_pend = have_pend_r;
  assign sts.out_free  = out_free;

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_slot_index = out_slot_r;
  assign out_overwrote  = out_over_r;
  assign out_draw_x     = out_x_r;
  assign out_draw_y     = out_y_r;
  assign out_draw_width = out_w_r;
  assign out_draw_color = out_c_r;
  assign out_last       = out_last_r;

  a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.add_commit || cmd.emit_pend || cmd.emit_none) |-> out_free)
    else $error("result loaded while result register busy");

  a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.add_commit, cmd.emit_none, cmd.emit_pend}))
    else $error("two result loads in one cycle");

  a_ss_range: assert property (@(posedge clk) disable iff (!rst_n)
    search_start_r <= IDX_MAX)
    else $error("search start beyond pool");

  a_tick_live: assert property (@(posedge clk) disable iff (!rst_n)
    (pipe_v_r && !cmd.add_commit && life_new == 16'd0) |=> !live_r[$past(pipe_idx_r)])
    else $error("expired slot still live");

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the particle pool with next-fit slot allocation.
`timescale 1ns / 100ps

module tb;
  import ppool_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int TAIL_CYCLES = 2 * POOL_SIZE_DEF;
  localparam int LONG_HOLD   = 400;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  slot_index;
    logic        overwrote;
    logic [15:0] draw_x;
    logic [15:0] draw_y;
    logic [15:0] draw_width;
    logic [31:0] draw_color;
    logic        last;
  } slot_result_t;

  // Slot pool predictor plus the queue of results it still owes.
  class slot_pool_model;
    logic [15:0]  decay;
    logic [15:0]  life [POOL_SIZE_DEF];
    logic [15:0]  xs [POOL_SIZE_DEF];
    logic [15:0]  ys [POOL_SIZE_DEF];
    logic [15:0]  ws [POOL_SIZE_DEF];
    logic [31:0]  cs [POOL_SIZE_DEF];
    logic [5:0]   next_start;
    slot_result_t due_results [$];
    int mismatches, n_alloc, n_over, n_drawn, n_none;

    function new();
      decay = DECAY_RESET;
      next_start = '0;
      for (int i = 0; i < POOL_SIZE_DEF; i++) begin
        life[i] = '0;
        xs[i] = '0;
        ys[i] = '0;
        ws[i] = '0;
        cs[i] = '0;
      end
      mismatches = 0;
      n_alloc = 0;
      n_over = 0;
      n_drawn = 0;
      n_none = 0;
    endfunction

    function void set_decay(logic [15:0] v);
      decay = v;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function void take_item(logic [1:0] op, logic [15:0] dt, logic [15:0] x,
                            logic [15:0] y, logic [15:0] w, logic [31:0] c);
      logic [31:0]  loss;
      logic [5:0]   slot;
      bit           found;
      int           idx;
      int           last_live;
      slot_result_t r;
      case (op)
        OP_TICK: begin
          loss = ({16'b0, decay} * {16'b0, dt}) >> 1;
          for (int i = 0; i < POOL_SIZE_DEF; i++)
            if (life[i] != 0)
              life[i] = ({16'b0, life[i]} > loss) ? life[i] - loss[15:0] : 16'd0;
        end
        OP_ADD: begin
          found = 1'b0;
          slot = '0;
          // next-fit: scan from the remembered slot and wrap around
          for (int k = 0; k < POOL_SIZE_DEF; k++) begin
            idx = (int'(next_start) + k) % POOL_SIZE_DEF;
            if (!found && life[idx] == 0) begin
              found = 1'b1;
              slot = 6'(idx);
            end
          end
          if (found) next_start = slot;
          else n_over++;
          life[slot] = LIFE_FULL;
          xs[slot] = x;
          ys[slot] = y;
          ws[slot] = w;
          cs[slot] = c;
          r = '0;
          r.kind = KIND_ALLOC;
          r.slot_index = slot;
          r.overwrote = !found;
          r.last = 1'b1;
          due_results.push_back(r);
          n_alloc++;
        end
        OP_DRAW: begin
          last_live = -1;
          for (int i = 0; i < POOL_SIZE_DEF; i++)
            if (life[i] != 0) last_live = i;
          if (last_live < 0) begin
            r = '0;
            r.kind = KIND_NONE;
            r.last = 1'b1;
            due_results.push_back(r);
            n_none++;
          end else begin
            for (int i = 0; i < POOL_SIZE_DEF; i++) begin
              if (life[i] != 0) begin
                r.kind = KIND_DRAW;
                r.slot_index = 6'(i);
                r.overwrote = 1'b0;
                r.draw_x = xs[i];
                r.draw_y = ys[i];
                r.draw_width = ws[i];
                r.draw_color = cs[i];
                r.last = (i == last_live);
                due_results.push_back(r);
                n_drawn++;
              end
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void compare_result(slot_result_t got);
      slot_result_t want;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result kind %0d slot %0d last %0d",
                   $time, got.kind, got.slot_index, got.last);
        return;
      end
      want = due_results.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: mismatch exp kind %0d slot %0d ovr %0d x %h y %h w %h c %h last %0d",
                   $time, want.kind, want.slot_index, want.overwrote, want.draw_x,
                   want.draw_y, want.draw_width, want.draw_color, want.last);
          $display("%0t:          got kind %0d slot %0d ovr %0d x %h y %h w %h c %h last %0d",
                   $time, got.kind, got.slot_index, got.overwrote, got.draw_x,
                   got.draw_y, got.draw_width, got.draw_color, got.last);
        end
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_operation;
  logic [15:0]        in_delta_time;
  logic signed [15:0] in_pos_x;
  logic signed [15:0] in_pos_y;
  logic [15:0]        in_width;
  logic [31:0]        in_color;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         out_kind;
  logic [5:0]         out_slot_index;
  logic               out_overwrote;
  logic signed [15:0] out_draw_x;
  logic signed [15:0] out_draw_y;
  logic [15:0]        out_draw_width;
  logic [31:0]        out_draw_color;
  logic               out_last;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  slot_pool_model pool;
  bit calm;
  bit hold_off_req;
  int n_ticks, n_ignored, n_writes;

  particle_pool_next_fit_allocator_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_delta_time  (in_delta_time),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_width       (in_width),
    .in_color       (in_color),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_slot_index (out_slot_index),
    .out_overwrote  (out_overwrote),
    .out_draw_x     (out_draw_x),
    .out_draw_y     (out_draw_y),
    .out_draw_width (out_draw_width),
    .out_draw_color (out_draw_color),
    .out_last       (out_last),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Result side: random stalls, one long hold-off on request, none once calm.
  initial begin : result_sink
    out_ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
      pool.compare_result({out_kind, out_slot_index, out_overwrote, out_draw_x, out_draw_y,
                           out_draw_width, out_draw_color, out_last});
  end

  task automatic send_item(input logic [1:0] op, input logic [15:0] dt,
                           input logic [15:0] x, input logic [15:0] y,
                           input logic [15:0] w, input logic [31:0] c);
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_delta_time <= dt;
    in_pos_x      <= x;
    in_pos_y      <= y;
    in_width      <= w;
    in_color      <= c;
    do @(posedge clk); while (in_ready !== 1'b1);
    pool.take_item(op, dt, x, y, w, c);
    if (op == OP_TICK) n_ticks++;
    if (op == OP_UNUSED) n_ignored++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // Hold the input until every owed result is out, then let a tick finish its sweep.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pool.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_decay_rate(input logic [15:0] v);
    drain_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_DECAY, 2'b00};
    pwdata  <= {16'b0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    pool.set_decay(v);
    n_writes++;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_mix(input int count, input int pct_add, input int pct_draw,
                         input int pct_tick);
    int          made;
    int          roll;
    logic [1:0]  op;
    logic [15:0] dt;
    made = 0;
    while (made < count) begin
      roll = $urandom_range(0, 99);
      if (roll < pct_add) op = OP_ADD;
      else if (roll < pct_add + pct_draw) op = OP_DRAW;
      else if (roll < pct_add + pct_draw + pct_tick) op = OP_TICK;
      else op = OP_UNUSED;
      case ($urandom_range(0, 7))
        0:          dt = '0;
        1, 2, 3, 4: dt = 16'($urandom_range(1, 127));
        default:    dt = 16'($urandom);
      endcase
      send_item(op, dt, 16'($urandom), 16'($urandom), 16'($urandom), $urandom);
      if (op != OP_UNUSED) made++;
    end
  endtask

  initial begin
    pool = new();
    calm = 1'b0;
    hold_off_req = 1'b0;
    n_ticks = 0;
    n_ignored = 0;
    n_writes = 0;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_operation  <= OP_TICK;
    in_delta_time <= '0;
    in_pos_x      <= '0;
    in_pos_y      <= '0;
    in_width      <= '0;
    in_color      <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty draw, field extremes, partial and exact decay.
    send_item(OP_DRAW, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0);
    send_item(OP_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0);
    send_item(OP_ADD, 16'h0000, 16'h8000, 16'h7fff, 16'h0000, 32'h0000_0000);
    send_item(OP_ADD, 16'hffff, 16'h7fff, 16'h8000, 16'hffff, 32'hffff_ffff);
    send_item(OP_ADD, 16'h0000, 16'hffff, 16'h0001, 16'h0001, 32'h8000_0001);
    send_item(OP_DRAW, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0);
    send_item(OP_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0);
    send_item(OP_TICK, 16'h0040, 16'h0000, 16'h0000, 16'h0000, 32'h0);
    send_item(OP_DRAW, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0);
    send_item(OP_UNUSED, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 32'hffff_ffff);
    send_item(OP_TICK, 16'h007f, 16'h0000, 16'h0000, 16'h0000, 32'h0);
    send_item(OP_ADD, 16'h0000, 16'h1234, 16'hedcb, 16'h5a5a, 32'h1234_5678);
    send_item(OP_DRAW, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0);
    send_item(OP_TICK, 16'hffff, 16'h0000, 16'h0000, 16'h0000, 32'h0);
    send_item(OP_DRAW, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0);
    send_item(OP_ADD, 16'h0000, 16'h0010, 16'hfff0, 16'h0100, 32'hdead_beef);
    send_item(OP_ADD, 16'h0000, 16'h0020, 16'hffe0, 16'h0200, 32'h0bad_f00d);
    send_item(OP_TICK, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 32'h0);
    send_item(OP_DRAW, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0);
    send_item(OP_TICK, 16'h0100, 16'h0000, 16'h0000, 16'h0000, 32'h0);
    send_item(OP_DRAW, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0);

    // No decay: fill the pool past full so slot 0 gets overwritten.
    write_decay_rate(16'h0000);
    run_mix(70, 90, 5, 5);
    // Stall the result side while items keep coming; full-pool draws back up.
    hold_off_req = 1'b1;
    run_mix(30, 40, 45, 10);

    // Maximum decay: any nonzero tick nearly or fully empties the pool.
    write_decay_rate(16'hffff);
    run_mix(40, 40, 30, 25);

    write_decay_rate(16'($urandom_range(1, 600)));
    run_mix(35, 50, 25, 20);
    write_decay_rate(16'($urandom_range(1, 300)));
    run_mix(35, 45, 25, 25);

    // Last part runs without idling on either side.
    write_decay_rate(16'($urandom_range(1, 300)));
    calm = 1'b1;
    run_mix(40, 45, 25, 25);

    drain_results();
    $display("items: %0d allocs (%0d overwrote slot 0), %0d ticks, %0d ignored, %0d writes",
             pool.n_alloc, pool.n_over, n_ticks, n_ignored, n_writes);
    $display("draws: %0d slot results, %0d empty-pool results, %0d mismatches",
             pool.n_drawn, pool.n_none, pool.mismatches);
    if (pool.mismatches == 0 && pool.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/ppool_pkg.sv
hw/rtl/ppool_ram.sv
hw/rtl/ppool_ctrl.sv
hw/rtl/ppool_dpath.sv
hw/rtl/particle_pool_next_fit_allocator_unit.sv
tb/sv/tb.sv
